### rtl/tcwrr_pkg.sv
package tcwrr_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_REQ = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_GRANTED  = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic CFG_WEIGHTS = 1'b0;
  localparam logic CFG_RTMASK  = 1'b1;

  localparam int SUM_W = 11;

  typedef struct packed {
    logic       opcode;
    logic [2:0] priority_req;
    logic [7:0] queue_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] grant_priority;
    logic [7:0] grant_queue_id;
    logic       grant_realtime;
  } out_item_t;

endpackage

### rtl/tcwrr_front.sv
// accepts items and parks them in a two-entry queue for the scheduler
module tcwrr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcwrr_pkg::in_item_t in_data,
  output logic                q_valid,
  input  logic                q_take,
  output tcwrr_pkg::in_item_t q_data
);

  tcwrr_pkg::in_item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (q_take) rd_r <= !rd_r;
    end
    if (push) mem_r[wr_r] <= in_data;
  end

endmodule

### rtl/tcwrr_back.sv
// scheduler: fifo store, credit counters and the level walk
module tcwrr_back #(
  parameter int NUM_LEVELS = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_wdata,
  input  logic                 q_valid,
  output logic                 q_take,
  input  tcwrr_pkg::in_item_t  q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcwrr_pkg::out_item_t out_data
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = $clog2(NUM_LEVELS * FIFO_DEPTH);
  localparam int SW = tcwrr_pkg::SUM_W;
  localparam logic [3:0] NLV = 4'(NUM_LEVELS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_END   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_ENQ   = 3'd5;

  logic [7:0]  store_r [NUM_LEVELS * FIFO_DEPTH];
  logic [PW-1:0] head_r [NUM_LEVELS];
  logic [PW-1:0] tail_r [NUM_LEVELS];
  logic [CW-1:0] cnt_r  [NUM_LEVELS];
  logic [7:0]  used_r [NUM_LEVELS];
  logic [SW-1:0] rsum_r, nsum_r;
  logic [63:0] wts_r;
  logic [7:0]  rtm_r;

  logic [2:0]  st_r;
  logic [LW-1:0] lv_r;
  logic        cls_r;      // 1 while walking the real-time class
  logic        pass_r;     // second pass flag
  logic        zfound_r;
  logic [LW-1:0] zlv_r;
  logic        gfound_r;
  logic [LW-1:0] glv_r;
  logic [7:0]  rd_id_r;
  tcwrr_pkg::out_item_t res_r;
  logic        ov_r;
  logic [SW-1:0] rws_r, nws_r;

  logic [7:0]  w;
  logic        lv_rt;
  logic [SW-1:0] csum;
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] enq_lv;
  logic        enq_ok;

  always_comb begin
    w     = wts_r[{lv_r, 3'b000} +: 8];
    lv_rt = rtm_r[lv_r];
    csum  = cls_r ? rsum_r : nsum_r;
  end

  // class weight sums, recomputed continuously from the weight and mask registers
  always_ff @(posedge clk) begin
    logic [SW-1:0] a, b;
    a = '0; b = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (rtm_r[i]) a = a + SW'(wts_r[8*i +: 8]);
      else          b = b + SW'(wts_r[8*i +: 8]);
    end
    rws_r <= a;
    nws_r <= b;
  end

  // enqueue target level and whether it has room
  assign enq_lv = q_data.priority_req[LW-1:0];
  assign enq_ok = ({1'b0, q_data.priority_req} < NLV)
                  && (cnt_r[enq_lv] < CW'(FIFO_DEPTH));

  assign waddr = AW'(32'(enq_lv) * FIFO_DEPTH + 32'(tail_r[enq_lv]));
  assign raddr = AW'(32'(glv_r) * FIFO_DEPTH + 32'(head_r[glv_r]));
  assign q_take = (st_r == S_ENQ) || (st_r == S_OUT);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (st_r == S_ENQ && enq_ok)
      store_r[waddr] <= q_data.queue_id;
    rd_id_r <= store_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      rsum_r <= '0;
      nsum_r <= '0;
      wts_r  <= 64'h0101010101010101;
      rtm_r  <= '0;
      lv_r <= '0; cls_r <= 1'b1; pass_r <= 1'b0;
      zfound_r <= 1'b0; zlv_r <= '0; gfound_r <= 1'b0; glv_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0; tail_r[i] <= '0; cnt_r[i] <= '0; used_r[i] <= '0;
      end
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == tcwrr_pkg::CFG_WEIGHTS) wts_r <= cfg_wdata;
        else rtm_r <= cfg_wdata[7:0];
        rsum_r <= '0; nsum_r <= '0;
        for (int i = 0; i < NUM_LEVELS; i++) used_r[i] <= '0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_valid && !ov_r) begin
            if (q_data.opcode == tcwrr_pkg::OP_ENQ) st_r <= S_ENQ;
            else begin
              st_r <= S_WALK; lv_r <= LW'(NUM_LEVELS - 1); cls_r <= 1'b1;
              pass_r <= 1'b0; zfound_r <= 1'b0; gfound_r <= 1'b0;
            end
          end
        end
        S_ENQ: begin
          if (!enq_ok)
            res_r <= '{tcwrr_pkg::ST_DROPPED, 3'd0, 8'd0, 1'b0};
          else begin
            res_r <= '{tcwrr_pkg::ST_ENQUEUED, 3'd0, 8'd0, 1'b0};
            tail_r[enq_lv] <= (tail_r[enq_lv] == PW'(FIFO_DEPTH - 1)) ? '0
                              : tail_r[enq_lv] + 1'b1;
            cnt_r[enq_lv] <= cnt_r[enq_lv] + 1'b1;
          end
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_WALK: begin
          // one level per cycle, highest first
          logic done;
          done = (lv_r == '0);
          if (lv_rt == cls_r) begin
            if (used_r[lv_r] < w) begin
              if (cnt_r[lv_r] == '0) begin
                if (cls_r) rsum_r <= rsum_r + SW'(w - used_r[lv_r]);
                else       nsum_r <= nsum_r + SW'(w - used_r[lv_r]);
                used_r[lv_r] <= w;
              end else begin
                used_r[lv_r] <= used_r[lv_r] + 1'b1;
                if (cls_r) rsum_r <= csum + 1'b1;
                else       nsum_r <= csum + 1'b1;
                gfound_r <= 1'b1; glv_r <= lv_r;
                done = 1'b1;
              end
            end else if (w == 8'd0 && cnt_r[lv_r] != '0) begin
              zfound_r <= 1'b1; zlv_r <= lv_r;
            end
          end
          if (!done) lv_r <= lv_r - 1'b1;
          else st_r <= S_END;
        end
        S_END: begin
          // end of one class walk
          if (!gfound_r && zfound_r) begin
            gfound_r <= 1'b1; glv_r <= zlv_r;
          end
          if (cls_r && !gfound_r && !zfound_r) begin
            cls_r <= 1'b0; lv_r <= LW'(NUM_LEVELS - 1); st_r <= S_WALK;
          end else begin
            for (int i = 0; i < NUM_LEVELS; i++)
              if (rtm_r[i] ? (rsum_r == rws_r) : (nsum_r == nws_r)) used_r[i] <= '0;
            if (rsum_r == rws_r) rsum_r <= '0;
            if (nsum_r == nws_r) nsum_r <= '0;
            if (gfound_r || zfound_r) st_r <= S_READ;
            else if (!pass_r) begin
              pass_r <= 1'b1; cls_r <= 1'b1; lv_r <= LW'(NUM_LEVELS - 1);
              st_r <= S_WALK;
            end else st_r <= S_OUT;
          end
        end
        S_READ: st_r <= S_OUT;  // store read in flight
        S_OUT: begin
          if (gfound_r) begin
            res_r <= '{tcwrr_pkg::ST_GRANTED, 3'(glv_r), rd_id_r, rtm_r[glv_r]};
            head_r[glv_r] <= (head_r[glv_r] == PW'(FIFO_DEPTH - 1)) ? '0
                             : head_r[glv_r] + 1'b1;
            cnt_r[glv_r]  <= cnt_r[glv_r] - 1'b1;
          end else res_r <= '{tcwrr_pkg::ST_NONE, 3'd0, 8'd0, 1'b0};
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/two_class_weighted_round_robin_top.sv
// two-class weighted round-robin scheduler over per-level queue-id fifos
// input channel: in_valid/in_stall carry one request (enqueue or grant
// request); every request returns exactly one result on out_valid/out_stall
// an enqueue result is loaded into the output register by the state that takes
// the request; the scheduler starts the next request in the cycle after a result
// leaves, so it takes no new request while a result is still waiting
// a grant request walks up to NUM_LEVELS levels per class, one level a
// cycle, with an end step after each class, for at most two passes, then
// a store read if a level was granted and the result step; the level walk
// dominates the time from acceptance to result
// a two-entry request queue sits in front of the scheduler so that new
// requests are taken while the scheduler is busy or its result is waiting
// when out_stall is high the result holds in the output register and the
// scheduler waits; the request queue fills and then raises in_stall
// reset (rst_n low, synchronous) empties all fifos, clears all credit and
// restores weights to one per level and all levels to the normal class
// cfg writes (cfg_we, cfg_index, cfg_wdata) must come only while no request
// is in flight; they clear all credit counters, fifo contents are kept
module two_class_weighted_round_robin_top #(
  parameter int NUM_LEVELS = 8,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcwrr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcwrr_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_wdata
);

  // queue between front and scheduler
  logic                q_valid, q_take;
  tcwrr_pkg::in_item_t q_data;

  tcwrr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_data
  );

  tcwrr_back #(.NUM_LEVELS(NUM_LEVELS), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .q_valid, .q_take, .q_data, .out_valid, .out_stall, .out_data
  );

endmodule

### verif/two_class_weighted_round_robin_top_tb.sv
module two_class_weighted_round_robin_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 8;
  localparam int DEPTH = 16;
  localparam int SETTLE = 60;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tcwrr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcwrr_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = tcwrr_pkg::CFG_WEIGHTS;
  logic [63:0] cfg_wdata = '0;

  two_class_weighted_round_robin_top #(.NUM_LEVELS(LEVELS), .FIFO_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // scheduler shadow state
  logic [63:0] sh_weights;
  logic [7:0]  sh_rtmask;
  logic [7:0]  sh_store [LEVELS][DEPTH];
  logic [3:0]  sh_head [LEVELS];
  logic [3:0]  sh_tail [LEVELS];
  logic [4:0]  sh_count [LEVELS];
  logic [7:0]  sh_credit [LEVELS];
  logic [10:0] sh_rt_sum, sh_nrt_sum;

  tcwrr_pkg::out_item_t grant_queue [$];
  int          errors = 0;
  bit          calm = 1'b0;   // no idling stretch
  longint      cycles = 0;

  function automatic logic [7:0] wt(int lv);
    return sh_weights[8*lv +: 8];
  endfunction

  function automatic void clear_credit();
    foreach (sh_credit[i]) sh_credit[i] = '0;
    sh_rt_sum = '0;
    sh_nrt_sum = '0;
  endfunction

  function automatic logic [10:0] weight_total(bit rt);
    logic [10:0] s;
    s = '0;
    for (int lv = 0; lv < LEVELS; lv++)
      if (sh_rtmask[lv] == rt) s += 11'(wt(lv));
    return s;
  endfunction

  // one class search, highest level first; -1 if nothing
  function automatic int search_class(bit rt);
    int zero_pick;
    logic [10:0] s;
    zero_pick = -1;
    s = rt ? sh_rt_sum : sh_nrt_sum;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (sh_rtmask[lv] != rt) continue;
      if (sh_credit[lv] < wt(lv)) begin
        if (sh_count[lv] == 0) begin
          // empty level forfeits remaining credit
          s += 11'(wt(lv) - sh_credit[lv]);
          sh_credit[lv] = wt(lv);
        end else begin
          sh_credit[lv]++;
          s += 11'd1;
          if (rt) sh_rt_sum = s; else sh_nrt_sum = s;
          return lv;
        end
      end else if (wt(lv) == 0 && sh_count[lv] != 0) begin
        zero_pick = lv;
      end
    end
    if (rt) sh_rt_sum = s; else sh_nrt_sum = s;
    return zero_pick;
  endfunction

  function automatic int sched_pass();
    int g;
    logic [10:0] rws, nws;
    g = search_class(1'b1);
    if (g < 0) g = search_class(1'b0);
    rws = weight_total(1'b1);
    nws = weight_total(1'b0);
    for (int lv = 0; lv < LEVELS; lv++)
      if (sh_rtmask[lv] ? (sh_rt_sum == rws) : (sh_nrt_sum == nws)) sh_credit[lv] = '0;
    if (sh_rt_sum == rws) sh_rt_sum = '0;
    if (sh_nrt_sum == nws) sh_nrt_sum = '0;
    return g;
  endfunction

  function automatic tcwrr_pkg::out_item_t predict_grant(tcwrr_pkg::in_item_t req);
    tcwrr_pkg::out_item_t r;
    int g;
    int p;
    r = '0;
    p = int'(req.priority_req);
    if (req.opcode == tcwrr_pkg::OP_ENQ) begin
      if (sh_count[p] >= DEPTH) begin
        r.status = tcwrr_pkg::ST_DROPPED;
      end else begin
        r.status = tcwrr_pkg::ST_ENQUEUED;
        sh_store[p][sh_tail[p]] = req.queue_id;
        sh_tail[p]++;
        sh_count[p]++;
      end
      return r;
    end
    g = sched_pass();
    if (g < 0) g = sched_pass();   // empty search repeated once
    if (g < 0) begin
      r.status = tcwrr_pkg::ST_NONE;
    end else begin
      r.status = tcwrr_pkg::ST_GRANTED;
      r.grant_priority = 3'(g);
      r.grant_queue_id = sh_store[g][sh_head[g]];
      r.grant_realtime = sh_rtmask[g];
      sh_head[g]++;
      sh_count[g]--;
    end
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 31);
  endfunction

  // send one request, valid held until accepted
  task automatic send_request(bit op, logic [2:0] pr, logic [7:0] id);
    tcwrr_pkg::in_item_t req;
    req.opcode = op;
    req.priority_req = pr;
    req.queue_id = id;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    grant_queue.push_back(predict_grant(req));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write while idle; credit clears in the shadow too
  task automatic write_reg(logic idx, logic [63:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcwrr_pkg::CFG_WEIGHTS) sh_weights = val;
    else sh_rtmask = val[7:0];
    clear_credit();
  endtask

  // result checking
  always @(posedge clk) begin
    tcwrr_pkg::out_item_t want;
    if (rst_n) out_stall <= idle_now();
    if (rst_n && out_valid && !out_stall) begin
      if (grant_queue.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = grant_queue.pop_front();
        if (out_data.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_data.status); errors++;
        end
        if (out_data.grant_priority !== want.grant_priority) begin
          $error("grant_priority exp %0d got %0d", want.grant_priority,
                 out_data.grant_priority); errors++;
        end
        if (out_data.grant_queue_id !== want.grant_queue_id) begin
          $error("grant_queue_id exp %0d got %0d", want.grant_queue_id,
                 out_data.grant_queue_id); errors++;
        end
        if (out_data.grant_realtime !== want.grant_realtime) begin
          $error("grant_realtime exp %0d got %0d", want.grant_realtime,
                 out_data.grant_realtime); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_class_weighted_round_robin_top_tb: errors");
      $finish;
    end
  end

  task automatic test_directed();
    // grant with nothing pending
    send_request(tcwrr_pkg::OP_REQ, 3'd0, 8'd0);
    // extremes of id and level
    send_request(tcwrr_pkg::OP_ENQ, 3'd7, 8'hff);
    send_request(tcwrr_pkg::OP_ENQ, 3'd0, 8'h00);
    send_request(tcwrr_pkg::OP_ENQ, 3'd5, 8'haa);
    send_request(tcwrr_pkg::OP_ENQ, 3'd2, 8'h55);
    repeat (5) send_request(tcwrr_pkg::OP_REQ, 3'(0), 8'd0);
    // fill level 3 past full to force drops
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(tcwrr_pkg::OP_ENQ, 3'd3, 8'(i * 17));
  endtask

  task automatic test_drain_full();
    for (int i = 0; i < DEPTH + 1; i++) send_request(tcwrr_pkg::OP_REQ, 3'd7, 8'hff);
  endtask

  task automatic test_zero_weights();
    // several zero-weight levels in each class
    write_reg(tcwrr_pkg::CFG_WEIGHTS, 64'h0300_0002_0000_0100);
    write_reg(tcwrr_pkg::CFG_RTMASK, 64'ha6);
    for (int i = 0; i < 12; i++)
      send_request(tcwrr_pkg::OP_ENQ, 3'(i % LEVELS), 8'(i));
    repeat (14) send_request(tcwrr_pkg::OP_REQ, 3'd0, 8'd0);
    // all weights zero, empty class weight sum
    write_reg(tcwrr_pkg::CFG_WEIGHTS, 64'h0);
    for (int i = 0; i < 6; i++) send_request(tcwrr_pkg::OP_ENQ, 3'(i), 8'(i + 40));
    repeat (7) send_request(tcwrr_pkg::OP_REQ, 3'd0, 8'd0);
  endtask

  task automatic random_phase(int n, bit op_bias);
    for (int i = 0; i < n; i++) begin
      bit op;
      op = ($urandom_range(99) < (op_bias ? 60 : 45));
      send_request(op, 3'($urandom_range(LEVELS - 1)), 8'($urandom));
    end
  endtask

  task automatic test_random();
    logic [63:0] w;
    // all-ones weights, all real-time; the weight sum 2040 fits in 11 bits
    write_reg(tcwrr_pkg::CFG_WEIGHTS, 64'hffff_ffff_ffff_ffff);
    write_reg(tcwrr_pkg::CFG_RTMASK, 64'hff);
    random_phase(180, 1'b0);
    // default-like weights, no real-time levels
    write_reg(tcwrr_pkg::CFG_WEIGHTS, 64'h0101_0101_0101_0101);
    write_reg(tcwrr_pkg::CFG_RTMASK, 64'h0);
    random_phase(160, 1'b1);
    // hold off until everything is back
    drain();
    calm = 1'b1;
    random_phase(200, 1'b0);
    calm = 1'b0;
    for (int k = 0; k < 4; k++) begin
      w = {$urandom, $urandom};
      // small weights mostly, with some zeros
      for (int lv = 0; lv < LEVELS; lv++)
        w[8*lv +: 8] = ($urandom_range(3) == 0) ? 8'd0 :
                       (($urandom_range(5) == 0) ? w[8*lv +: 8] : 8'($urandom_range(1, 4)));
      write_reg(tcwrr_pkg::CFG_WEIGHTS, w);
      write_reg(tcwrr_pkg::CFG_RTMASK, 64'(8'($urandom)));
      random_phase(140, k[0]);
    end
  endtask

  initial begin
    sh_weights = 64'h0101_0101_0101_0101;
    sh_rtmask = '0;
    foreach (sh_count[i]) begin
      sh_head[i] = '0; sh_tail[i] = '0; sh_count[i] = '0;
    end
    clear_credit();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_full();
    test_zero_weights();
    test_random();
    drain();
    if (errors == 0) $display("two_class_weighted_round_robin_top_tb: clean");
    else $display("two_class_weighted_round_robin_top_tb: errors");
    $finish;
  end
endmodule
